[src/oqv_pkg.sv]
// Shared types, sizes and codes for the ordered queue with value operations.
package oqv_pkg;

   localparam int DEPTH  = 16;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int WORD_W = 32;
   localparam int LEN_W  = 5;
   localparam int STAT_W = 2;
   localparam int OP_W   = 3;

   typedef enum logic [OP_W-1:0] {
      OP_ENQ = 3'd0,
      OP_DEQ = 3'd1,
      OP_DEL = 3'd2,
      OP_INS = 3'd3,
      OP_UPD = 3'd4
   } op_type;

   localparam logic [STAT_W-1:0] ST_DONE      = 2'd0;
   localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;
   localparam logic [STAT_W-1:0] ST_EMPTY     = 2'd3;

   typedef struct packed {
      logic [OP_W-1:0]          opcode;
      logic signed [WORD_W-1:0] first_value;
      logic signed [WORD_W-1:0] second_value;
   } req_type;

   typedef struct packed {
      logic [STAT_W-1:0]        status;
      logic [LEN_W-1:0]         length;
      logic signed [WORD_W-1:0] front_value;
      logic signed [WORD_W-1:0] rear_value;
   } rsp_type;

   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] waddr;
      logic [WORD_W-1:0] wdata;
      logic              re;
      logic [ADDR_W-1:0] raddr;
   } mem_req_type;

endpackage

[src/oqv_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module oqv_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[src/oqv_walker.sv]
// Operation sequencer: decodes an item, walks the entry memory and reads back front and rear.
module oqv_walker (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  oqv_pkg::req_type    req_data,
   output logic                res_valid,
   input  logic                res_take,
   output oqv_pkg::rsp_type    res_data,
   output oqv_pkg::mem_req_type mem_req,
   input  logic [oqv_pkg::WORD_W-1:0] mem_rdata
);
   import oqv_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_WALK,
      S_RB0,
      S_RB1,
      S_RB2,
      S_DONE
   } state_type;

   typedef enum logic [1:0] {
      MODE_DEL,
      MODE_INS,
      MODE_UPD
   } mode_type;

   state_type         state_ff, state_in;
   mode_type          mode_ff, mode_in;
   logic              deq_ff, deq_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [WORD_W-1:0] key_ff, key_in;
   logic [WORD_W-1:0] word_ff, word_in;
   logic [WORD_W-1:0] carry_ff, carry_in;
   logic              matched_ff, matched_in;
   logic [CNT_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic              pend_valid_ff, pend_valid_in;
   logic [ADDR_W-1:0] pend_addr_ff, pend_addr_in;
   logic [STAT_W-1:0] status_ff, status_in;
   logic [WORD_W-1:0] front_ff, front_in;
   logic [WORD_W-1:0] rear_ff, rear_in;

   logic              is_empty, is_full, hit;
   logic [CNT_W-1:0]  count_m1;

   assign is_empty = (count_ff == '0);
   assign is_full  = (count_ff == CNT_W'(DEPTH));
   assign count_m1 = count_ff - CNT_W'(1);
   assign hit      = !matched_ff &&
                     (deq_ff ? (pend_addr_ff == '0) : (mem_rdata == key_ff));

   // Writes always land at or behind the entry just read, so the read
   // pointer never meets a pending write and no forwarding is needed.
   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      deq_in        = deq_ff;
      count_in      = count_ff;
      key_in        = key_ff;
      word_in       = word_ff;
      carry_in      = carry_ff;
      matched_in    = matched_ff;
      rd_ptr_in     = rd_ptr_ff;
      pend_valid_in = pend_valid_ff;
      pend_addr_in  = pend_addr_ff;
      status_in     = status_ff;
      front_in      = front_ff;
      rear_in       = rear_ff;
      mem_req       = '0;
      req_ready     = 1'b0;
      res_valid     = 1'b0;

      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               key_in        = req_data.first_value;
               word_in       = req_data.second_value;
               carry_in      = req_data.second_value;
               matched_in    = 1'b0;
               rd_ptr_in     = '0;
               pend_valid_in = 1'b0;
               deq_in        = 1'b0;
               status_in     = ST_DONE;
               case (req_data.opcode)
                  OP_ENQ: begin
                     if (is_full) begin
                        status_in = ST_FULL;
                        state_in  = S_DONE;
                     end else begin
                        mem_req.we    = 1'b1;
                        mem_req.waddr = count_ff[ADDR_W-1:0];
                        mem_req.wdata = req_data.first_value;
                        count_in      = count_ff + CNT_W'(1);
                        state_in      = S_RB0;
                     end
                  end
                  OP_DEQ: begin
                     if (is_empty) begin
                        status_in = ST_EMPTY;
                        state_in  = S_DONE;
                     end else begin
                        mode_in  = MODE_DEL;
                        deq_in   = 1'b1;
                        state_in = S_WALK;
                     end
                  end
                  OP_DEL: begin
                     if (is_empty) begin
                        status_in = ST_EMPTY;
                        state_in  = S_DONE;
                     end else begin
                        mode_in  = MODE_DEL;
                        state_in = S_WALK;
                     end
                  end
                  OP_INS: begin
                     if (is_empty) begin
                        status_in = ST_EMPTY;
                        state_in  = S_DONE;
                     end else if (is_full) begin
                        status_in = ST_FULL;
                        state_in  = S_DONE;
                     end else if (rear_ff == req_data.first_value) begin
                        // rear matches: append, whatever matches earlier
                        mem_req.we    = 1'b1;
                        mem_req.waddr = count_ff[ADDR_W-1:0];
                        mem_req.wdata = req_data.second_value;
                        count_in      = count_ff + CNT_W'(1);
                        state_in      = S_RB0;
                     end else begin
                        mode_in  = MODE_INS;
                        state_in = S_WALK;
                     end
                  end
                  OP_UPD: begin
                     if (is_empty) begin
                        status_in = ST_EMPTY;
                        state_in  = S_DONE;
                     end else begin
                        mode_in  = MODE_UPD;
                        state_in = S_WALK;
                     end
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end

         S_WALK: begin
            if (rd_ptr_ff != count_ff) begin
               mem_req.re    = 1'b1;
               mem_req.raddr = rd_ptr_ff[ADDR_W-1:0];
               rd_ptr_in     = rd_ptr_ff + CNT_W'(1);
               pend_valid_in = 1'b1;
               pend_addr_in  = rd_ptr_ff[ADDR_W-1:0];
            end else begin
               pend_valid_in = 1'b0;
            end

            if (pend_valid_ff) begin
               case (mode_ff)
                  MODE_DEL: begin
                     // past the match, every entry moves one slot forward
                     if (matched_ff) begin
                        mem_req.we    = 1'b1;
                        mem_req.waddr = pend_addr_ff - ADDR_W'(1);
                        mem_req.wdata = mem_rdata;
                     end
                     if (hit) begin
                        matched_in = 1'b1;
                     end
                  end
                  MODE_INS: begin
                     // from the match on, carry the displaced entry rearward
                     if (hit || matched_ff) begin
                        mem_req.we    = 1'b1;
                        mem_req.waddr = pend_addr_ff;
                        mem_req.wdata = carry_ff;
                        carry_in      = mem_rdata;
                        matched_in    = 1'b1;
                     end
                  end
                  MODE_UPD: begin
                     if (hit) begin
                        mem_req.we    = 1'b1;
                        mem_req.waddr = pend_addr_ff;
                        mem_req.wdata = word_ff;
                        matched_in    = 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
            end else if (rd_ptr_ff == count_ff) begin
               case (mode_ff)
                  MODE_DEL: begin
                     if (matched_ff) begin
                        count_in = count_m1;
                     end else begin
                        status_in = ST_NOT_FOUND;
                     end
                  end
                  MODE_INS: begin
                     // no match leaves the new word in carry: plain append
                     mem_req.we    = 1'b1;
                     mem_req.waddr = count_ff[ADDR_W-1:0];
                     mem_req.wdata = carry_ff;
                     count_in      = count_ff + CNT_W'(1);
                  end
                  MODE_UPD: begin
                     if (!matched_ff) begin
                        status_in = ST_NOT_FOUND;
                     end
                  end
                  default: begin
                  end
               endcase
               state_in = S_RB0;
            end
         end

         S_RB0: begin
            if (is_empty) begin
               front_in = '0;
               rear_in  = '0;
               state_in = S_DONE;
            end else begin
               mem_req.re    = 1'b1;
               mem_req.raddr = '0;
               state_in      = S_RB1;
            end
         end

         S_RB1: begin
            front_in      = mem_rdata;
            mem_req.re    = 1'b1;
            mem_req.raddr = count_m1[ADDR_W-1:0];
            state_in      = S_RB2;
         end

         S_RB2: begin
            rear_in  = mem_rdata;
            state_in = S_DONE;
         end

         S_DONE: begin
            res_valid = 1'b1;
            if (res_take) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         matched_ff    <= 1'b0;
         pend_valid_ff <= 1'b0;
         front_ff      <= '0;
         rear_ff       <= '0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         matched_ff    <= matched_in;
         pend_valid_ff <= pend_valid_in;
         front_ff      <= front_in;
         rear_ff       <= rear_in;
      end
      mode_ff      <= mode_in;
      deq_ff       <= deq_in;
      key_ff       <= key_in;
      word_ff      <= word_in;
      carry_ff     <= carry_in;
      rd_ptr_ff    <= rd_ptr_in;
      pend_addr_ff <= pend_addr_in;
      status_ff    <= status_in;
   end

   assign res_data.status      = status_ff;
   assign res_data.length      = LEN_W'(count_ff);
   assign res_data.front_value = front_ff;
   assign res_data.rear_value  = rear_ff;

endmodule

[src/ordered_queue_with_value_ops.sv]
// Top level: ordered queue of signed words with search, delete, insert and update.
//
// One item is worked at a time. Enqueue, and insert whose key matches the rear,
// write the entry and then read back front and rear before the result is
// returned; dequeue, delete, update and other inserts first walk every held
// entry through the single read port of the entry memory, DEPTH entries at most.
// Rejected items (full, empty, unused opcode) go straight to the result. The
// next item is accepted once the result has moved into the output register,
// which then holds it until rsp_ready.
module ordered_queue_with_value_ops (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  oqv_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output oqv_pkg::rsp_type rsp_data
);
   import oqv_pkg::*;

   mem_req_type       mem_req;
   logic [WORD_W-1:0] mem_rdata;
   logic              res_valid, res_take;
   rsp_type           res_data;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff;

   oqv_ram #(
      .WIDTH (WORD_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (mem_req.we),
      .waddr (mem_req.waddr),
      .wdata (mem_req.wdata),
      .re    (mem_req.re),
      .raddr (mem_req.raddr),
      .rdata (mem_rdata)
   );

   oqv_walker u_walker (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .res_valid (res_valid),
      .res_take  (res_take),
      .res_data  (res_data),
      .mem_req   (mem_req),
      .mem_rdata (mem_rdata)
   );

   assign res_take = res_valid && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (res_take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (res_take) begin
         rsp_data_ff <= res_data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // an accepted item keeps the input closed until its result is handed off
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input accepted again while an item is in progress");

   a_no_accept_with_result: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> !req_ready)
      else $error("input open while a finished result is pending");

   a_rsp_from_result: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(res_valid))
      else $error("output became valid without a finished result");

   a_no_write_when_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready && !req_valid |-> !mem_req.we && !mem_req.re)
      else $error("memory accessed while idle");

endmodule
